>>> rtl/core/pab_pkg.sv
// Shared widths, command codes and register indexes for the graph builder.
`default_nettype none
package pab_pkg;
   localparam int CMD_W      = 1;
   localparam int DRAW_W     = 32;
   localparam int NODE_W     = 10;
   localparam int DEG_W      = 16;
   localparam int NC_W       = 11;
   localparam int LPN_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CMD_W-1:0] CMD_RESTART = 1'b0;
   localparam logic [CMD_W-1:0] CMD_DRAW    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINKS_PER_NODE = 2'd1;

   localparam logic [NC_W-1:0]  NODE_COUNT_RESET = 11'd1024;
   localparam logic [LPN_W-1:0] LINKS_RESET      = 2'd2;

   localparam int SEED_NODES = 3;
   localparam int MIN_NODES  = 4;
   localparam logic [DEG_W-1:0] SEED_DEG   = 16'd2;
   localparam logic [DEG_W-1:0] SEED_TOTAL = 16'd6;
   localparam logic [DEG_W-1:0] DEG_STEP   = 16'd2;
endpackage
`default_nettype wire

>>> rtl/core/pab_req_if.sv
// Request channel: command and random draw.
`default_nettype none
interface pab_req_if;
   import pab_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DRAW_W-1:0] random_draw;
   modport source (output valid, command, random_draw, input ready);
   modport sink   (input valid, command, random_draw, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pab_rsp_if.sv
// Response channel: one edge of the graph.
`default_nettype none
interface pab_rsp_if;
   import pab_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] new_node;
   logic [NODE_W-1:0] target_node;
   logic              last;
   modport source (output valid, new_node, target_node, last, input ready);
   modport sink   (input valid, new_node, target_node, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pab_csr_if.sv
// Register write channel: index and data.
`default_nettype none
interface pab_csr_if;
   import pab_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/preferential_attachment_graph_builder_core.sv
// Preferential attachment graph builder: degree table, sampler and sequencer.
//
// Grows a scale-free graph from a seed triangle, one draw item at a time; each
// accepted target comes out as one edge (new_node, target_node). A draw keeps
// the request side busy until its scan, degree updates and edge hand-off are
// done, plus any wait for the output register to free up: the sampler first
// forms the threshold on the 32x16 multiplier, then walks the degree memory
// through its single registered read port, one entry and one add-compare per
// cycle, at most up to the current node; the two degree updates share the one
// write port. A restart item, and reset, rewrite the seed degrees in the INIT
// state; draws after the graph is finished, and rejected draws, give no edge.
// The request side is not ready while an item is in progress; a pending edge
// waits in an output register.
`default_nettype none
module preferential_attachment_graph_builder_core #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_LINKS = 3
) (
   input  wire       clock,
   input  wire       reset,
   pab_req_if.sink   req_ch,
   pab_rsp_if.source rsp_ch,
   pab_csr_if.sink   csr_ch
);
   import pab_pkg::*;

   localparam int AW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int LKW = $clog2(MAX_LINKS + 1);
   localparam int LW  = (CW > NC_W) ? CW : NC_W;
   localparam int LPW = (LKW > LPN_W) ? LKW : LPN_W;
   localparam int SW  = DEG_W + AW;
   localparam int PW  = DRAW_W + DEG_W;

   typedef enum logic [6:0] {
      ST_INIT = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_SCAN = 7'b0001000,
      ST_WCUR = 7'b0010000,
      ST_WTGT = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        init_cnt_ff, init_cnt_in;
   logic [NC_W-1:0]   ncount_ff, ncount_in;
   logic [LPN_W-1:0]  lpn_ff, lpn_in;
   logic [CW-1:0]     cur_ff, cur_in;
   logic [LKW-1:0]    links_ff, links_in;
   logic [DEG_W-1:0]  total_ff, total_in;
   logic              finished_ff, finished_in;
   logic [AW-1:0]     step_ff [MAX_LINKS];
   logic [AW-1:0]     step_in [MAX_LINKS];
   logic [DRAW_W-1:0] draw_ff, draw_in;
   logic [DEG_W-1:0]  thr_ff, thr_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic              dv_ff, dv_in;
   logic [AW-1:0]     didx_ff;
   logic [DEG_W-1:0]  rdata_ff;
   logic [AW-1:0]     tgt_ff, tgt_in;
   logic [DEG_W-1:0]  tdeg_ff, tdeg_in;
   logic              last_ff, last_in;
   logic [NODE_W-1:0] own_ff, own_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_new_ff, rsp_new_in;
   logic [NODE_W-1:0] rsp_tgt_ff, rsp_tgt_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [DEG_W-1:0]  deg_mem [MAX_NODES];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DEG_W-1:0]  mem_wdata;

   logic [LW-1:0]     nc_ext, lim_w;
   logic [CW-1:0]     limit;
   logic [LPW-1:0]    lpn_ext, eff_w;
   logic [LKW-1:0]    eff_links;
   logic [PW-1:0]     product;
   logic [DEG_W-1:0]  scan_deg;
   logic [SW-1:0]     sum_next;
   logic              hit, at_cur, dup;
   logic [LKW-1:0]    links_next;
   logic [CW-1:0]     cur_next;
   logic              req_fire;

   // effective register values
   always_comb begin
      nc_ext = LW'(ncount_ff);
      if (nc_ext < LW'(MIN_NODES)) begin
         lim_w = LW'(MIN_NODES);
      end else if (nc_ext > LW'(MAX_NODES)) begin
         lim_w = LW'(MAX_NODES);
      end else begin
         lim_w = nc_ext;
      end
      limit   = CW'(lim_w);
      lpn_ext = LPW'(lpn_ff);
      if (lpn_ext == '0) begin
         eff_w = LPW'(1);
      end else if (lpn_ext > LPW'(MAX_LINKS)) begin
         eff_w = LPW'(MAX_LINKS);
      end else begin
         eff_w = lpn_ext;
      end
      eff_links = LKW'(eff_w);
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.new_node    = rsp_new_ff;
   assign rsp_ch.target_node = rsp_tgt_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // sampler datapath; degree of the node being inserted equals its links so far
   assign product  = PW'(draw_ff) * PW'(total_ff);
   assign at_cur   = (CW'(didx_ff) == cur_ff);
   assign scan_deg = at_cur ? DEG_W'(links_ff) : rdata_ff;
   assign sum_next = sum_ff + SW'(scan_deg);
   assign hit      = dv_ff && (sum_next > SW'(thr_ff));

   always_comb begin
      dup = 1'b0;
      for (int k = 0; k < MAX_LINKS; k++) begin
         if ((LKW'(k) < links_ff) && (step_ff[k] == didx_ff)) begin
            dup = 1'b1;
         end
      end
   end

   assign links_next = LKW'(links_ff + LKW'(1));
   assign cur_next   = CW'(cur_ff + CW'(1));

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tgt_ff;
      mem_wdata = DEG_W'(tdeg_ff + DEG_W'(1));
      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(init_cnt_ff);
            mem_wdata = SEED_DEG;
         end
         ST_WCUR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff[AW-1:0];
            mem_wdata = DEG_W'(DEG_W'(links_ff) + DEG_W'(1));
         end
         ST_WTGT: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      ncount_in   = ncount_ff;
      lpn_in      = lpn_ff;
      cur_in      = cur_ff;
      links_in    = links_ff;
      total_in    = total_ff;
      finished_in = finished_ff;
      for (int k = 0; k < MAX_LINKS; k++) begin
         step_in[k] = step_ff[k];
      end
      draw_in      = draw_ff;
      thr_in       = thr_ff;
      sum_in       = sum_ff;
      rd_addr_in   = rd_addr_ff;
      dv_in        = 1'b0;
      tgt_in       = tgt_ff;
      tdeg_in      = tdeg_ff;
      last_in      = last_ff;
      own_in       = own_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_new_in   = rsp_new_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         if (csr_ch.index == CSR_NODE_COUNT) begin
            ncount_in = csr_ch.data[NC_W-1:0];
         end else if (csr_ch.index == CSR_LINKS_PER_NODE) begin
            lpn_in = csr_ch.data[LPN_W-1:0];
         end
      end

      case (state_ff)
         ST_INIT: begin
            init_cnt_in = 2'(init_cnt_ff + 2'd1);
            if (init_cnt_ff == 2'(SEED_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == CMD_RESTART) begin
                  cur_in      = CW'(SEED_NODES);
                  links_in    = '0;
                  total_in    = SEED_TOTAL;
                  finished_in = 1'b0;
                  init_cnt_in = '0;
                  state_in    = ST_INIT;
               end else if (finished_ff) begin
                  state_in = ST_IDLE;
               end else if (cur_ff >= limit) begin
                  finished_in = 1'b1;
               end else begin
                  draw_in  = req_ch.random_draw;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            thr_in     = product[PW-1:DRAW_W];
            sum_in     = '0;
            rd_addr_in = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr_in = AW'(rd_addr_ff + AW'(1));
            dv_in      = (CW'(rd_addr_ff) <= cur_ff);
            if (dv_ff) begin
               sum_in = sum_next;
               if (hit) begin
                  tgt_in  = didx_ff;
                  tdeg_in = scan_deg;
                  dv_in   = 1'b0;
                  state_in = (at_cur || dup) ? ST_IDLE : ST_WCUR;
               end else if (at_cur) begin
                  dv_in    = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WCUR: begin
            state_in = ST_WTGT;
         end
         ST_WTGT: begin
            for (int k = 0; k < MAX_LINKS; k++) begin
               if (LKW'(k) == links_ff) begin
                  step_in[k] = tgt_ff;
               end
            end
            total_in = DEG_W'(total_ff + DEG_STEP);
            own_in   = NODE_W'(cur_ff);
            last_in  = 1'b0;
            if (links_next >= eff_links) begin
               links_in = '0;
               cur_in   = cur_next;
               if (cur_next >= limit) begin
                  finished_in = 1'b1;
                  last_in     = 1'b1;
               end
            end else begin
               links_in = links_next;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_new_in   = own_ff;
               rsp_tgt_in   = NODE_W'(tgt_ff);
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deg_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= deg_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         ncount_ff    <= NODE_COUNT_RESET;
         lpn_ff       <= LINKS_RESET;
         cur_ff       <= CW'(SEED_NODES);
         links_ff     <= '0;
         total_ff     <= SEED_TOTAL;
         finished_ff  <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         ncount_ff    <= ncount_in;
         lpn_ff       <= lpn_in;
         cur_ff       <= cur_in;
         links_ff     <= links_in;
         total_ff     <= total_in;
         finished_ff  <= finished_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_LINKS; k++) begin
         step_ff[k] <= step_in[k];
      end
      draw_ff     <= draw_in;
      thr_ff      <= thr_in;
      sum_ff      <= sum_in;
      rd_addr_ff  <= rd_addr_in;
      didx_ff     <= rd_addr_ff;
      tgt_ff      <= tgt_in;
      tdeg_ff     <= tdeg_in;
      last_ff     <= last_in;
      own_ff      <= own_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_tgt_ff  <= rsp_tgt_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef NO_ASSERTIONS
   a_links_bound: assert property (@(posedge clock) disable iff (reset)
      links_ff < LKW'(MAX_LINKS))
      else $error("links count reached its limit without completing the node");

   a_total_even: assert property (@(posedge clock) disable iff (reset)
      total_ff[0] == 1'b0)
      else $error("total degree is odd");

   a_scan_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (sum_ff <= SW'(thr_ff)))
      else $error("running sum passed threshold without a hit");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && dv_ff) |-> (CW'(didx_ff) <= cur_ff))
      else $error("scan ran past the node being inserted");

   a_emit_edge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WTGT) |=>
         (state_ff == ST_EMIT && !($past(tgt_ff) == $past(cur_ff[AW-1:0]))))
      else $error("edge to the node being inserted");
`endif
endmodule
`default_nettype wire
